// ----- rtl/hwg_pkg.sv -----
// shared constants and types of the homography warp grid
`default_nettype none
package hwg_pkg;
	localparam int LANES_DEF      = 4;
	localparam int COORD_BITS_DEF = 12;
	localparam int COEF_W         = 32;
	localparam int OFF_W          = 48;
	localparam int GUARD_W        = 32;
	localparam int CFG_W          = 64;
	localparam int CFG_IDX_W      = 3;
	localparam int OUT_W          = 16;
	localparam int Q_FRAC         = 28;
	localparam int SCALE_SH       = 4;
	localparam int LANE_LAT       = 3;
	localparam int DIV_LAT        = OUT_W + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_U_SLOPES = 3'd0,
		REG_U_OFFSET = 3'd1,
		REG_V_SLOPES = 3'd2,
		REG_V_OFFSET = 3'd3,
		REG_W_SLOPES = 3'd4,
		REG_W_OFFSET = 3'd5,
		REG_W_GUARD  = 3'd6
	} hwg_reg_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] hc;
		logic signed [COEF_W-1:0] hr;
		logic signed [OFF_W-1:0]  off;
	} hwg_term_t;

	typedef struct packed {
		hwg_term_t           u;
		hwg_term_t           v;
		hwg_term_t           w;
		logic [GUARD_W-1:0]  guard;
	} hwg_cfg_t;
endpackage
`default_nettype wire

// ----- rtl/hwg_lane.sv -----
// one lane: projective terms, guard on w, magnitudes for the dividers
`default_nettype none
module hwg_lane
	import hwg_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int LANE_IDX   = 0,
	parameter int ACC_W      = 58
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [COORD_BITS-1:0] row,
	input  wire logic [COORD_BITS-1:0] col_base,
	input  wire hwg_cfg_t              cfg,
	output logic [ACC_W+SCALE_SH-1:0]  num_u,
	output logic [ACC_W+SCALE_SH-1:0]  num_v,
	output logic [ACC_W-1:0]           den,
	output logic                       neg_u,
	output logic                       neg_v
);
	localparam int CB_W   = COORD_BITS + 3;
	localparam int PROD_W = COEF_W + CB_W + 1;

	logic [CB_W-1:0] col;
	logic signed [CB_W:0] col_s, row_s;
	logic signed [PROD_W-1:0] puc_s1, pur_s1, pvc_s1, pvr_s1, pwc_s1, pwr_s1;
	logic signed [ACC_W-1:0] u_s2, v_s2, w_s2;
	logic [ACC_W-1:0] mag_u, mag_v, mag_w;

	assign col   = CB_W'(col_base) + CB_W'(LANE_IDX);
	assign col_s = $signed({1'b0, col});
	assign row_s = $signed({1'b0, CB_W'(row)});

	always_ff @(posedge clk) begin
		if (en) begin
			puc_s1 <= PROD_W'(cfg.u.hc * col_s);
			pur_s1 <= PROD_W'(cfg.u.hr * row_s);
			pvc_s1 <= PROD_W'(cfg.v.hc * col_s);
			pvr_s1 <= PROD_W'(cfg.v.hr * row_s);
			pwc_s1 <= PROD_W'(cfg.w.hc * col_s);
			pwr_s1 <= PROD_W'(cfg.w.hr * row_s);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s2 <= ACC_W'(puc_s1) + ACC_W'(pur_s1) + ACC_W'(cfg.u.off);
			v_s2 <= ACC_W'(pvc_s1) + ACC_W'(pvr_s1) + ACC_W'(cfg.v.off);
			w_s2 <= ACC_W'(pwc_s1) + ACC_W'(pwr_s1) + ACC_W'(cfg.w.off);
		end
	end

	assign mag_u = u_s2[ACC_W-1] ? ACC_W'(-u_s2) : ACC_W'(u_s2);
	assign mag_v = v_s2[ACC_W-1] ? ACC_W'(-v_s2) : ACC_W'(v_s2);
	assign mag_w = w_s2[ACC_W-1] ? ACC_W'(-w_s2) : ACC_W'(w_s2);

	// guarded w becomes one, which is positive
	always_ff @(posedge clk) begin
		if (en) begin
			num_u <= {mag_u, SCALE_SH'(0)};
			num_v <= {mag_v, SCALE_SH'(0)};
			if (mag_w <= ACC_W'(cfg.guard)) begin
				den   <= ACC_W'(1) << Q_FRAC;
				neg_u <= u_s2[ACC_W-1];
				neg_v <= v_s2[ACC_W-1];
			end else begin
				den   <= mag_w;
				neg_u <= u_s2[ACC_W-1] ^ w_s2[ACC_W-1];
				neg_v <= v_s2[ACC_W-1] ^ w_s2[ACC_W-1];
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/hwg_div.sv -----
// pipelined restoring divider, one quotient bit per stage, saturated output
`default_nettype none
module hwg_div
	import hwg_pkg::*;
#(
	parameter int ACC_W = 58
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [ACC_W+SCALE_SH-1:0] num,
	input  wire logic [ACC_W-1:0]        den,
	input  wire logic                    neg,
	output logic signed [OUT_W-1:0]      q
);
	localparam int CW = ACC_W + OUT_W + 1;

	logic [CW-1:0]    rem_s [0:OUT_W-1];
	logic [ACC_W-1:0] den_s [0:OUT_W-1];
	logic [OUT_W-1:0] quo_s [0:OUT_W];
	logic             neg_s [0:OUT_W];
	logic             ovf_s [0:OUT_W];
	logic [OUT_W-1:0] mag;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= CW'(num);
			den_s[0] <= den;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= CW'(num) >= (CW'(den) << OUT_W);
		end
	end

	for (genvar k = 1; k <= OUT_W; k++) begin : g_stage
		logic [CW-1:0] sub;
		logic          take;
		assign sub  = CW'(den_s[k-1]) << (OUT_W - k);
		assign take = rem_s[k-1] >= sub;
		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= {quo_s[k-1][OUT_W-2:0], take};
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
		if (k < OUT_W) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? rem_s[k-1] - sub : rem_s[k-1];
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign mag = quo_s[OUT_W];

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[OUT_W]) begin
				if (ovf_s[OUT_W] || (mag > (OUT_W'(1) << (OUT_W - 1))))
					q <= {1'b1, (OUT_W-1)'(0)};
				else
					q <= OUT_W'(-mag);
			end else begin
				if (ovf_s[OUT_W] || mag[OUT_W-1])
					q <= {1'b0, {(OUT_W-1){1'b1}}};
				else
					q <= mag;
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/homography_warp_grid_q12_4.sv -----
// top level: configuration registers, lanes, dividers and output packing
// throughput: one word per cycle; every stage advances together when the
// output register is empty or being taken
// reset: configuration returns to the identity mapping, pipeline emptied
`default_nettype none
module homography_warp_grid_q12_4
	import hwg_pkg::*;
#(
	parameter int LANES      = LANES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [CFG_IDX_W-1:0]            cfg_addr,
	input  wire logic [CFG_W-1:0]                cfg_wdata,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// row, col_base
	input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// u_lane0..u_lane(LANES-1), v_lane0..v_lane(LANES-1)
	output logic [2*LANES*OUT_W-1:0]             m_tdata
);
	localparam int PROD_W = COEF_W + COORD_BITS + 4;
	localparam int ACC_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 2;
	localparam int LAT    = LANE_LAT + DIV_LAT;

	hwg_cfg_t        cfg_q;
	logic [LAT-1:0]  vld_q;
	logic            en;
	logic [COORD_BITS-1:0] row, col_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.u.hc  <= COEF_W'(1) << Q_FRAC;
			cfg_q.u.hr  <= '0;
			cfg_q.u.off <= '0;
			cfg_q.v.hc  <= '0;
			cfg_q.v.hr  <= COEF_W'(1) << Q_FRAC;
			cfg_q.v.off <= '0;
			cfg_q.w.hc  <= '0;
			cfg_q.w.hr  <= '0;
			cfg_q.w.off <= OFF_W'(1) << Q_FRAC;
			cfg_q.guard <= GUARD_W'(32);
		end else if (cfg_we) begin
			case (hwg_reg_t'(cfg_addr))
				REG_U_SLOPES: {cfg_q.u.hc, cfg_q.u.hr} <= cfg_wdata;
				REG_U_OFFSET: cfg_q.u.off <= cfg_wdata[OFF_W-1:0];
				REG_V_SLOPES: {cfg_q.v.hc, cfg_q.v.hr} <= cfg_wdata;
				REG_V_OFFSET: cfg_q.v.off <= cfg_wdata[OFF_W-1:0];
				REG_W_SLOPES: {cfg_q.w.hc, cfg_q.w.hr} <= cfg_wdata;
				REG_W_OFFSET: cfg_q.w.off <= cfg_wdata[OFF_W-1:0];
				REG_W_GUARD:  cfg_q.guard <= cfg_wdata[GUARD_W-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];
	assign row      = s_tdata[COORD_BITS-1:0];
	assign col_base = s_tdata[2*COORD_BITS-1:COORD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [ACC_W+SCALE_SH-1:0] num_u, num_v;
		logic [ACC_W-1:0]          den;
		logic                      neg_u, neg_v;
		logic signed [OUT_W-1:0]   qu, qv;

		hwg_lane #(.COORD_BITS(COORD_BITS), .LANE_IDX(l), .ACC_W(ACC_W)) u_lane (
			.clk(clk), .en(en), .row(row), .col_base(col_base), .cfg(cfg_q),
			.num_u(num_u), .num_v(num_v), .den(den), .neg_u(neg_u), .neg_v(neg_v)
		);

		hwg_div #(.ACC_W(ACC_W)) u_div_u (
			.clk(clk), .en(en), .num(num_u), .den(den), .neg(neg_u), .q(qu)
		);

		hwg_div #(.ACC_W(ACC_W)) u_div_v (
			.clk(clk), .en(en), .num(num_v), .den(den), .neg(neg_v), .q(qv)
		);

		assign m_tdata[l*OUT_W +: OUT_W]           = qu;
		assign m_tdata[(LANES+l)*OUT_W +: OUT_W]   = qv;
	end
endmodule
`default_nettype wire
